FILE: hw/rtl/piecewise_linear_time_profile_core_macros.svh
// Assertion macros shared by the piecewise linear time profile RTL.
`ifndef PIECEWISE_LINEAR_TIME_PROFILE_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_TIME_PROFILE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PLTP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pltp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PLTP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pltp assertion failed");

`endif

FILE: hw/rtl/pltp_pkg.sv
// Shared types and constants of the piecewise linear time profile core.
`default_nettype none

package pltp_pkg;

  localparam int IDX_BITS  = 6;
  localparam int CFG_BITS  = 7;
  localparam int STAT_BITS = 2;
  localparam int MUL_SLICE = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [STAT_BITS-1:0] STAT_INTERP = 2'd0;
  localparam logic [STAT_BITS-1:0] STAT_LOW    = 2'd1;
  localparam logic [STAT_BITS-1:0] STAT_HIGH   = 2'd2;
  localparam logic [STAT_BITS-1:0] STAT_NONE   = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/piecewise_linear_time_profile_core.sv
// Breakpoint time profile: table store, interval scan and linear interpolation.
// A write gives no result. A query tests entry 0 for the low clamp, then the last entry for
//   the high clamp, else scans one entry a cycle and, when interpolating, runs the serial
//   multiply and the one-bit-a-cycle divider before the result goes to the output register.
// Throughput: writes back to back; one query in work, next taken the cycle after hand-off.
// Reset (rst_n low, synchronous) clears control, points_in_use to 1; table undefined.
`default_nettype none
`include "piecewise_linear_time_profile_core_macros.svh"

module piecewise_linear_time_profile_core #(
  parameter int MAX_POINTS = 64,
  parameter int TIME_BITS  = 32,
  parameter int AMP_BITS   = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // configuration: points_in_use
  input  wire logic                             cfg_wr_en,
  input  wire logic [pltp_pkg::CFG_BITS-1:0]    cfg_wr_data,

  // input beats
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata: entry_index, entry_time, entry_amplitude, query_time, zero fill
  input  wire logic [((pltp_pkg::IDX_BITS + 2*TIME_BITS + AMP_BITS + 7)/8)*8-1:0] in_tdata,
  // tuser: action
  input  wire logic                             in_tuser,

  // result beats
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata: amplitude, zero fill
  output logic [((AMP_BITS + 7)/8)*8-1:0]       out_tdata,
  // tuser: status
  output logic [pltp_pkg::STAT_BITS-1:0]        out_tuser
);

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int IW    = pltp_pkg::IDX_BITS;
  localparam int OUT_W = ((AMP_BITS + 7) / 8) * 8;
  localparam int MW    = TIME_BITS + AMP_BITS;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // take beats, writes go straight in
  localparam logic [2:0] S_CHK0 = 3'd1;  // entry 0 arriving: low clamp test
  localparam logic [2:0] S_CHKN = 3'd2;  // last entry arriving: high clamp test
  localparam logic [2:0] S_SCAN = 3'd3;  // one entry a cycle, pair with previous
  localparam logic [2:0] S_CALC = 3'd4;  // waiting on multiply/divide
  localparam logic [2:0] S_FIN  = 3'd5;  // hand result to output register

  logic [2:0]                     state_r, state_nxt;
  logic [pltp_pkg::CFG_BITS-1:0]  cfg_points_r;
  logic                           out_valid_r;
  logic [AMP_BITS-1:0]            out_amp_r;
  logic [pltp_pkg::STAT_BITS-1:0] out_stat_r;
  logic [AMP_BITS-1:0]            res_amp_r;
  logic [pltp_pkg::STAT_BITS-1:0] res_stat_r;
  logic [TIME_BITS-1:0]           q_t_r;
  logic [TIME_BITS-1:0]           prev_t_r;
  logic [AMP_BITS-1:0]            prev_a_r;
  logic [AW-1:0]                  idx_r;
  logic                           neg_r;

  // field unpacking
  logic [IW-1:0]        in_idx;
  logic [TIME_BITS-1:0] in_etime;
  logic [AMP_BITS-1:0]  in_eamp;
  logic [TIME_BITS-1:0] in_qtime;

  assign in_idx   = in_tdata[IW-1:0];
  assign in_etime = in_tdata[IW+TIME_BITS-1:IW];
  assign in_eamp  = in_tdata[IW+MW-1:IW+TIME_BITS];
  assign in_qtime = in_tdata[IW+MW+TIME_BITS-1:IW+MW];

  logic in_acc;
  logic fin_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // points in use, clamped to 1..MAX_POINTS, as the index of the last point
  logic [AW-1:0] last_idx;

  always_comb begin
    if (cfg_points_r == '0) begin
      last_idx = '0;
    end else if (32'(cfg_points_r) > 32'(MAX_POINTS)) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(cfg_points_r - 1'b1);
    end
  end

  // Breakpoint store. Writes happen only in idle and every read is issued
  // after that, so a read never meets a write to the same entry in flight.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [MW-1:0] mem_rdata;
  logic [TIME_BITS-1:0] rd_t;
  logic [AMP_BITS-1:0]  rd_a;

  assign mem_we    = in_acc && (in_tuser == pltp_pkg::ACT_WRITE) &&
                     (32'(in_idx) < 32'(MAX_POINTS));
  assign mem_waddr = AW'(in_idx);
  assign rd_t      = mem_rdata[MW-1:AMP_BITS];
  assign rd_a      = mem_rdata[AMP_BITS-1:0];

  always_comb begin
    case (state_r)
      S_IDLE:  mem_raddr = '0;
      S_CHK0:  mem_raddr = last_idx;
      S_CHKN:  mem_raddr = AW'(1);
      S_SCAN:  mem_raddr = idx_r + 1'b1;
      default: mem_raddr = '0;
    endcase
  end

  pltp_mem #(
    .DEPTH (MAX_POINTS),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({in_etime, in_eamp}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // interval test on (previous entry, arriving entry)
  logic                 hit;
  logic                 den_zero;
  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS-1:0] dt;
  logic [AMP_BITS:0]    diff;
  logic [AMP_BITS:0]    mag_full;

  assign hit      = (prev_t_r <= q_t_r) && (q_t_r <= rd_t);
  assign den      = rd_t - prev_t_r;
  assign den_zero = (den == '0);
  assign dt       = q_t_r - prev_t_r;
  assign diff     = {rd_a[AMP_BITS-1], rd_a} - {prev_a_r[AMP_BITS-1], prev_a_r};
  assign mag_full = diff[AMP_BITS] ? ((AMP_BITS+1)'(0) - diff) : diff;

  logic                md_start;
  pltp_pkg::md_stat_t  md_stat;
  logic [AMP_BITS-1:0] md_quo;

  assign md_start = (state_r == S_SCAN) && hit && !den_zero;

  pltp_muldiv #(
    .AMP_BITS  (AMP_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .mag   (mag_full[AMP_BITS-1:0]),
    .dt    (dt),
    .den   (den),
    .stat  (md_stat),
    .quo   (md_quo)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == pltp_pkg::ACT_QUERY)) begin
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: state_nxt = (q_t_r <= rd_t) ? S_FIN : S_CHKN;
      S_CHKN: state_nxt = (q_t_r >= rd_t) ? S_FIN : S_SCAN;
      S_SCAN: begin
        if (hit) begin
          state_nxt = den_zero ? S_FIN : S_CALC;
        end else if (idx_r == last_idx) begin
          state_nxt = S_FIN;
        end
      end
      S_CALC: begin
        if (md_stat.done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_points_r <= pltp_pkg::CFG_BITS'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_points_r <= cfg_wr_data;
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          q_t_r <= in_qtime;
        end
      end
      S_CHK0: begin
        prev_t_r   <= rd_t;
        prev_a_r   <= rd_a;
        res_amp_r  <= rd_a;
        res_stat_r <= pltp_pkg::STAT_LOW;
      end
      S_CHKN: begin
        res_amp_r  <= rd_a;
        res_stat_r <= pltp_pkg::STAT_HIGH;
        idx_r      <= AW'(1);
      end
      S_SCAN: begin
        if (hit) begin
          // zero-length interval answers the lower amplitude as it stands
          res_amp_r  <= prev_a_r;
          res_stat_r <= pltp_pkg::STAT_INTERP;
          neg_r      <= diff[AMP_BITS];
        end else begin
          prev_t_r   <= rd_t;
          prev_a_r   <= rd_a;
          idx_r      <= idx_r + 1'b1;
          res_amp_r  <= '0;
          res_stat_r <= pltp_pkg::STAT_NONE;
        end
      end
      S_CALC: begin
        if (md_stat.done) begin
          res_amp_r <= neg_r ? (prev_a_r - md_quo) : (prev_a_r + md_quo);
        end
      end
      default: ;
    endcase
    if (fin_load) begin
      out_amp_r  <= res_amp_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_amp_r);
  assign out_tuser  = out_stat_r;

  // divider is never restarted mid-run
  `PLTP_ASSERT_IMPL(a_start_idle, md_start, !md_stat.busy)
  // scan never runs past the last point in use
  `PLTP_ASSERT_IMPL(a_scan_bound, state_r == S_SCAN, idx_r <= last_idx)
  // a new result appears only after the hand-off state
  `PLTP_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_r), $past(state_r == S_FIN))
  // calculation waits for the divider
  `PLTP_ASSERT_NEXT(a_calc_hold, (state_r == S_CALC) && !md_stat.done, state_r == S_CALC)

endmodule

`default_nettype wire

FILE: hw/rtl/pltp_mem.sv
// Breakpoint store: one write port, one registered read port.
`default_nettype none

module pltp_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pltp_muldiv.sv
// Serial multiply (16-bit slices) then radix-2 restoring divide.
`default_nettype none

module pltp_muldiv #(
  parameter int AMP_BITS  = 32,
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [AMP_BITS-1:0]   mag,
  input  wire logic [TIME_BITS-1:0]  dt,
  input  wire logic [TIME_BITS-1:0]  den,
  output pltp_pkg::md_stat_t         stat,
  output logic      [AMP_BITS-1:0]   quo
);

  localparam int SL   = pltp_pkg::MUL_SLICE;
  localparam int MC   = (TIME_BITS + SL - 1) / SL;
  localparam int DTW  = MC * SL;
  localparam int PW   = AMP_BITS + DTW;
  localparam int CMAX = (MC > AMP_BITS) ? MC : AMP_BITS;
  localparam int CW   = $clog2(CMAX + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_LOAD = 2'd2;
  localparam logic [1:0] P_DIV  = 2'd3;

  logic [1:0]           phase_r, phase_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 done_r;
  logic [AMP_BITS-1:0]  mag_r;
  logic [DTW-1:0]       dt_r;
  logic [TIME_BITS-1:0] den_r;
  logic [PW-1:0]        acc_r;
  logic [TIME_BITS:0]   rem_r;
  logic [AMP_BITS-1:0]  low_r;

  logic [SL-1:0]          chunk;
  logic [AMP_BITS+SL-1:0] prod_chunk;
  logic [PW-1:0]          acc_nxt;
  logic [TIME_BITS:0]     rem_sh;
  logic                   ge;

  assign chunk      = dt_r[DTW-1 -: SL];
  assign prod_chunk = (AMP_BITS+SL)'(mag_r) * (AMP_BITS+SL)'(chunk);
  assign acc_nxt    = (acc_r << SL) + PW'(prod_chunk);
  // remainder stays below den, so its top bit is always clear
  assign rem_sh     = {rem_r[TIME_BITS-1:0], low_r[AMP_BITS-1]};
  assign ge         = rem_sh >= {1'b0, den_r};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          phase_nxt = P_MUL;
          cnt_nxt   = '0;
        end
      end
      P_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(MC - 1)) begin
          phase_nxt = P_LOAD;
        end
      end
      P_LOAD: begin
        phase_nxt = P_DIV;
        cnt_nxt   = '0;
      end
      P_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(AMP_BITS - 1)) begin
          phase_nxt = P_IDLE;
        end
      end
      default: phase_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= (phase_r == P_DIV) && (cnt_r == CW'(AMP_BITS - 1));
    end
  end

  always_ff @(posedge clk) begin
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          mag_r <= mag;
          dt_r  <= DTW'(dt);
          den_r <= den;
          acc_r <= '0;
        end
      end
      P_MUL: begin
        acc_r <= acc_nxt;
        dt_r  <= dt_r << SL;
      end
      P_LOAD: begin
        // quotient < 2^AMP_BITS, so the high part starts below den
        rem_r <= {1'b0, acc_r[AMP_BITS+TIME_BITS-1:AMP_BITS]};
        low_r <= acc_r[AMP_BITS-1:0];
      end
      P_DIV: begin
        rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        low_r <= {low_r[AMP_BITS-2:0], ge};
      end
      default: ;
    endcase
  end

  assign stat.busy = (phase_r != P_IDLE);
  assign stat.done = done_r;
  assign quo       = low_r;

endmodule

`default_nettype wire
